[rtl/vfts_pkg.sv]
// Shared types and constants of the video frame type sniffer.
package vfts_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_CODEC_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAMING    = 2'd1;

  localparam logic [1:0] CODEC_H264   = 2'd0;
  localparam logic [1:0] CODEC_MPEG12 = 2'd1;
  localparam logic [1:0] CODEC_MPEG4  = 2'd2;
  localparam logic [1:0] CODEC_NONE   = 2'd3;

  localparam logic [7:0] MPEG12_LAST_PICTURE = 8'h80;
  localparam logic [7:0] MPEG4_VOP_CODE      = 8'hB6;
  localparam logic [4:0] NAL_IDR_SLICE       = 5'd5;
  localparam logic [4:0] NAL_FIRST_SLICE     = 5'd1;

  typedef enum logic [1:0] {
    FT_UNKNOWN = 2'd0,
    FT_I       = 2'd1,
    FT_P       = 2'd2,
    FT_B       = 2'd3
  } frame_type_t;

  typedef struct packed {
    logic [1:0] codec_mode;
    logic       start_code_framing;
  } cfg_t;

  // Exp-Golomb decoder state; value saturates, its top bit marking 16 or more.
  typedef struct packed {
    logic       in_info;
    logic [5:0] count;
    logic [4:0] value;
    logic       field;
  } golomb_t;

  typedef struct packed {
    logic        valid;
    frame_type_t ftype;
  } result_t;

endpackage

[rtl/video_frame_type_sniffer.sv]
// Top level of the video frame type sniffer.
//
// Input channel: stream_byte with last_byte, handshake in_valid / in_ready.
// One word is one byte of a compressed frame buffer; last_byte marks the end.
// Output channel: frame_type (0 unknown, 1 I, 2 P, 3 B), handshake
// out_valid / out_ready, one word for every frame buffer.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 codec
// mode, 1 H.264 start-code framing) at the clock edge; a write restarts
// the parse of the current frame. Write only while the block is idle.
// Throughput is one byte per cycle while in_ready is high: the whole byte,
// including all eight Exp-Golomb bit steps, is handled by the logic between
// the parse state registers and the output queue. The result of a frame is
// registered in the output queue when its final byte is accepted.
// Reset (rst, synchronous) clears the registers to H.264 with a length
// prefix, clears the parse state and empties the output queue.
// When the receiver stalls, a two-entry output queue keeps bytes flowing;
// in_ready falls only while both entries hold results.
module video_frame_type_sniffer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [7:0]                       stream_byte,
  input  logic                             last_byte,
  input  logic                             in_valid,
  output logic                             in_ready,
  output logic [1:0]                       frame_type,
  output logic                             out_valid,
  input  logic                             out_ready,
  input  logic                             cfg_we,
  input  logic [vfts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [vfts_pkg::CFG_DATA_W-1:0]  cfg_data
);

  vfts_pkg::cfg_t        cfg;
  vfts_pkg::result_t     result;
  vfts_pkg::frame_type_t out_type;
  logic                  clear;
  logic                  accept;
  logic                  space;

  assign clear = cfg_we && (cfg_index == vfts_pkg::REG_CODEC_MODE ||
                            cfg_index == vfts_pkg::REG_FRAMING);
  assign accept = in_valid && in_ready;
  assign in_ready = space;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.codec_mode <= vfts_pkg::CODEC_H264;
      cfg.start_code_framing <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vfts_pkg::REG_CODEC_MODE: cfg.codec_mode <= cfg_data[1:0];
        vfts_pkg::REG_FRAMING:    cfg.start_code_framing <= cfg_data[0];
        default: ;
      endcase
    end
  end

  vfts_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .clear       (clear),
    .accept      (accept),
    .stream_byte (stream_byte),
    .last_byte   (last_byte),
    .result      (result)
  );

  vfts_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (result),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_type  (out_type)
  );

  assign frame_type = out_type;

endmodule

[rtl/vfts_golomb.sv]
// Exp-Golomb decoder that steps through the eight bits of one payload byte, stopping at a decision.
module vfts_golomb (
  input  vfts_pkg::golomb_t     state,
  input  logic [7:0]            stream_byte,
  output vfts_pkg::golomb_t     state_next,
  output logic                  decide,
  output vfts_pkg::frame_type_t decided_type
);

  function automatic vfts_pkg::frame_type_t slice_class(input logic [4:0] value);
    vfts_pkg::frame_type_t t;
    case (value) inside
      5'd2, 5'd7:    t = vfts_pkg::FT_B;
      [5'd1:5'd10]:  t = vfts_pkg::FT_P;
      default:       t = vfts_pkg::FT_UNKNOWN;
    endcase
    return t;
  endfunction

  vfts_pkg::golomb_t g;
  logic dec;
  vfts_pkg::frame_type_t ft;
  logic bit_v;
  logic check;

  always_comb begin
    g = state;
    dec = 1'b0;
    ft = vfts_pkg::FT_UNKNOWN;
    bit_v = 1'b0;
    check = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!dec) begin
        bit_v = stream_byte[i];
        check = 1'b1;
        if (!g.in_info) begin
          if (!bit_v) begin
            g.count = g.count + 6'd1;
            check = 1'b0;
            if (g.count > 6'd31) begin
              dec = 1'b1;
              ft = vfts_pkg::FT_UNKNOWN;
            end
          end else begin
            g.value = 5'd1;
            g.in_info = 1'b1;
          end
        end else begin
          g.value = {g.value[4] | g.value[3], g.value[2:0], bit_v};
          g.count = g.count - 6'd1;
        end
        if (check && g.count == 6'd0) begin
          if (!g.field) begin
            g.field = 1'b1;
            g.count = 6'd0;
            g.value = 5'd0;
            g.in_info = 1'b0;
          end else begin
            dec = 1'b1;
            ft = slice_class(g.value);
          end
        end
      end
    end
  end

  assign state_next   = g;
  assign decide       = dec;
  assign decided_type = ft;

endmodule

[rtl/vfts_parser.sv]
// Per-frame parse state and the byte rules for each codec.
module vfts_parser (
  input  logic              clk,
  input  logic              rst,
  input  vfts_pkg::cfg_t    cfg,
  input  logic              clear,
  input  logic              accept,
  input  logic [7:0]        stream_byte,
  input  logic              last_byte,
  output vfts_pkg::result_t result
);

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SCAN,
    PH_HDR,
    PH_TAIL,
    PH_GOLOMB
  } phase_t;

  phase_t                phase, phase_next;
  logic [1:0]            zero_run, zero_run_next;
  logic [2:0]            offset, offset_next;
  vfts_pkg::golomb_t     gstate, gstate_next;
  logic                  decided, decided_next;
  vfts_pkg::frame_type_t dtype, dtype_next;

  vfts_pkg::golomb_t     g_after;
  logic                  g_decide;
  vfts_pkg::frame_type_t g_type;

  phase_t                cb_phase;
  logic [1:0]            cb_zero_run;
  logic [2:0]            cb_offset;
  logic                  cb_decide;
  vfts_pkg::frame_type_t cb_type;
  logic                  cb_golomb;

  logic [1:0]            scan_zero_run;
  logic                  scan_found;
  logic [2:0]            lead_target;
  logic [2:0]            offset_inc;
  logic [2:0]            pct_mpeg12;

  vfts_golomb u_golomb (
    .state        (gstate),
    .stream_byte  (stream_byte),
    .state_next   (g_after),
    .decide       (g_decide),
    .decided_type (g_type)
  );

  always_comb begin
    scan_found = 1'b0;
    if (stream_byte == 8'd0) begin
      scan_zero_run = (zero_run == 2'd2) ? 2'd2 : zero_run + 2'd1;
    end else begin
      scan_zero_run = 2'd0;
      scan_found = (stream_byte == 8'd1) && (zero_run == 2'd2);
    end
  end

  // Start code value or NAL header byte.
  always_comb begin
    cb_phase = phase;
    cb_zero_run = zero_run;
    cb_offset = offset;
    cb_decide = 1'b0;
    cb_type = vfts_pkg::FT_UNKNOWN;
    cb_golomb = 1'b0;
    if (cfg.codec_mode == vfts_pkg::CODEC_H264) begin
      if (stream_byte[4:0] >= vfts_pkg::NAL_FIRST_SLICE &&
          stream_byte[4:0] <= vfts_pkg::NAL_IDR_SLICE) begin
        if (stream_byte[4:0] == vfts_pkg::NAL_IDR_SLICE) begin
          cb_decide = 1'b1;
          cb_type = vfts_pkg::FT_I;
        end else if (stream_byte[6:5] != 2'd0) begin
          cb_decide = 1'b1;
          cb_type = vfts_pkg::FT_P;
        end else begin
          cb_phase = PH_GOLOMB;
          cb_golomb = 1'b1;
        end
      end else if (cfg.start_code_framing) begin
        cb_phase = PH_SCAN;
        cb_zero_run = (stream_byte == 8'd0) ? 2'd1 : 2'd0;
      end else begin
        cb_decide = 1'b1;
      end
    end else if ((cfg.codec_mode == vfts_pkg::CODEC_MPEG12 &&
                  stream_byte > vfts_pkg::MPEG12_LAST_PICTURE) ||
                 (cfg.codec_mode == vfts_pkg::CODEC_MPEG4 &&
                  stream_byte != vfts_pkg::MPEG4_VOP_CODE)) begin
      cb_phase = PH_SCAN;
      cb_zero_run = 2'd0;
    end else begin
      cb_phase = PH_TAIL;
      cb_offset = 3'd3;
    end
  end

  assign lead_target = (cfg.codec_mode == vfts_pkg::CODEC_H264) ? 3'd4 : 3'd3;
  assign offset_inc  = offset + 3'd1;
  assign pct_mpeg12  = stream_byte[5:3];

  always_comb begin
    phase_next = phase;
    zero_run_next = zero_run;
    offset_next = offset;
    gstate_next = gstate;
    decided_next = decided;
    dtype_next = dtype;
    if (accept && !decided && cfg.codec_mode != vfts_pkg::CODEC_NONE) begin
      unique case (phase)
        PH_LEAD, PH_HDR: begin
          if (phase == PH_LEAD && cfg.codec_mode == vfts_pkg::CODEC_H264 &&
              cfg.start_code_framing) begin
            phase_next = PH_SCAN;
            zero_run_next = (stream_byte == 8'd0) ? 2'd1 : 2'd0;
          end else if (phase == PH_HDR || offset == lead_target) begin
            phase_next = cb_phase;
            zero_run_next = cb_zero_run;
            offset_next = cb_offset;
            if (cb_golomb) begin
              gstate_next = '0;
            end
            if (cb_decide) begin
              decided_next = 1'b1;
              dtype_next = cb_type;
            end
          end else begin
            offset_next = offset_inc;
          end
        end
        PH_SCAN: begin
          zero_run_next = scan_zero_run;
          if (scan_found) begin
            phase_next = PH_HDR;
          end
        end
        PH_TAIL: begin
          offset_next = offset_inc;
          if (cfg.codec_mode == vfts_pkg::CODEC_MPEG12) begin
            if (offset_inc == 3'd5) begin
              decided_next = 1'b1;
              dtype_next = pct_mpeg12[2] ? vfts_pkg::FT_UNKNOWN
                                         : vfts_pkg::frame_type_t'(pct_mpeg12[1:0]);
            end
          end else if (offset_inc == 3'd4) begin
            decided_next = 1'b1;
            case (stream_byte[7:6])
              2'd0:    dtype_next = vfts_pkg::FT_I;
              2'd1:    dtype_next = vfts_pkg::FT_P;
              2'd2:    dtype_next = vfts_pkg::FT_B;
              default: dtype_next = vfts_pkg::FT_UNKNOWN;
            endcase
          end
        end
        PH_GOLOMB: begin
          gstate_next = g_after;
          if (g_decide) begin
            decided_next = 1'b1;
            dtype_next = g_type;
          end
        end
        default: begin
          decided_next = 1'b1;
          dtype_next = vfts_pkg::FT_UNKNOWN;
        end
      endcase
    end
  end

  always_comb begin
    result.valid = accept && last_byte;
    result.ftype = decided_next ? dtype_next : vfts_pkg::FT_UNKNOWN;
  end

  always_ff @(posedge clk) begin
    if (rst || clear || (accept && last_byte)) begin
      phase <= PH_LEAD;
      zero_run <= 2'd0;
      offset <= 3'd0;
      gstate <= '0;
      decided <= 1'b0;
      dtype <= vfts_pkg::FT_UNKNOWN;
    end else begin
      phase <= phase_next;
      zero_run <= zero_run_next;
      offset <= offset_next;
      gstate <= gstate_next;
      decided <= decided_next;
      dtype <= dtype_next;
    end
  end

`ifndef SYNTHESIS
  a_frame_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte && !clear |=> phase == PH_LEAD && !decided && offset == 3'd0)
    else $error("parse state not cleared after final byte");
  a_unsupported_never_decides: assert property (@(posedge clk) disable iff (rst)
    cfg.codec_mode == vfts_pkg::CODEC_NONE |-> !decided)
    else $error("decision made in unsupported codec mode");
`endif

endmodule

[rtl/vfts_result_queue.sv]
// Two-entry output queue holding frame type results for the receiver.
module vfts_result_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  vfts_pkg::result_t     push,
  output logic                  space,
  output logic                  out_valid,
  input  logic                  out_ready,
  output vfts_pkg::frame_type_t out_type
);

  logic                  skid_valid, skid_valid_next;
  vfts_pkg::frame_type_t skid_type, skid_type_next;
  logic                  head_valid, head_valid_next;
  vfts_pkg::frame_type_t head_type, head_type_next;
  logic                  pop;

  assign pop   = head_valid && out_ready;
  assign space = !skid_valid;

  always_comb begin
    head_valid_next = head_valid;
    head_type_next = head_type;
    skid_valid_next = skid_valid;
    skid_type_next = skid_type;
    if (pop) begin
      head_valid_next = skid_valid;
      head_type_next = skid_type;
      skid_valid_next = 1'b0;
    end
    if (push.valid) begin
      if (!head_valid_next) begin
        head_valid_next = 1'b1;
        head_type_next = push.ftype;
      end else begin
        skid_valid_next = 1'b1;
        skid_type_next = push.ftype;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      head_valid <= head_valid_next;
      skid_valid <= skid_valid_next;
    end
    head_type <= head_type_next;
    skid_type <= skid_type_next;
  end

  assign out_valid = head_valid;
  assign out_type  = head_type;

`ifndef SYNTHESIS
  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> head_valid)
    else $error("second entry held with empty head");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !skid_valid)
    else $error("result pushed into full queue");
`endif

endmodule

[tb/video_frame_type_sniffer_tb.sv]
// Self-checking testbench for the video frame type sniffer: directed frames, then random streams.
`timescale 1ns / 1ps

module video_frame_type_sniffer_tb;

  typedef enum logic [2:0] {
    SP_LEAD,
    SP_SCAN,
    SP_HDR,
    SP_TAIL,
    SP_GZ,
    SP_GI
  } sniff_phase_t;

  typedef struct {
    logic [1:0]  mode;
    logic        framing;
    int          len;
    logic [95:0] data;
    int          fixed_type;
  } frame_row_t;

  localparam int NO_FIXED_TYPE = -1;
  localparam int ITEM_TARGET   = 1550;

  logic                             clk         = 1'b0;
  logic                             rst         = 1'b1;
  logic [7:0]                       stream_byte = 8'h00;
  logic                             last_byte   = 1'b0;
  logic                             in_valid    = 1'b0;
  logic                             in_ready;
  logic [1:0]                       frame_type;
  logic                             out_valid;
  logic                             out_ready   = 1'b0;
  logic                             cfg_we      = 1'b0;
  logic [vfts_pkg::CFG_INDEX_W-1:0] cfg_index   = '0;
  logic [vfts_pkg::CFG_DATA_W-1:0]  cfg_data    = '0;

  // Sniffer model state and its copy of the registers.
  logic [1:0]            model_mode;
  logic                  model_framing;
  sniff_phase_t          sn_phase;
  logic [1:0]            sn_zero_run;
  logic [2:0]            sn_offset;
  logic [5:0]            sn_gz_count;
  logic [31:0]           sn_gvalue;
  logic                  sn_gfield;
  logic                  sn_decided;
  vfts_pkg::frame_type_t sn_type;

  vfts_pkg::frame_type_t expected_types[$];
  int                    fixed_types[$];
  logic [7:0]            frame_buf[$];
  bit                    slice_bits[$];

  logic [1:0]            cur_mode    = vfts_pkg::CODEC_H264;
  logic                  cur_framing = 1'b0;
  bit                    quiet       = 1'b0;
  int                    fail_cnt    = 0;
  int                    bytes_seen  = 0;
  int                    frames_seen = 0;
  int                    phases      = 0;
  int                    type_seen[4];
  vfts_pkg::frame_type_t type_now;
  int                    fixed_now;

  video_frame_type_sniffer u_dut (
    .clk         (clk),
    .rst         (rst),
    .stream_byte (stream_byte),
    .last_byte   (last_byte),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .frame_type  (frame_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void clear_frame_state();
    sn_phase    = SP_LEAD;
    sn_zero_run = '0;
    sn_offset   = '0;
    sn_gz_count = '0;
    sn_gvalue   = '0;
    sn_gfield   = 1'b0;
    sn_decided  = 1'b0;
    sn_type     = vfts_pkg::FT_UNKNOWN;
  endfunction

  function automatic void settle_type(vfts_pkg::frame_type_t t);
    sn_decided = 1'b1;
    sn_type    = t;
  endfunction

  function automatic bit start_code_seen(logic [7:0] b);
    if (b == 8'h00) begin
      if (sn_zero_run < 2) sn_zero_run = sn_zero_run + 2'd1;
      return 1'b0;
    end
    if (b == 8'h01 && sn_zero_run >= 2) begin
      sn_zero_run = '0;
      return 1'b1;
    end
    sn_zero_run = '0;
    return 1'b0;
  endfunction

  function automatic void golomb_field_done();
    logic [31:0] v;
    v = sn_gvalue - 32'd1;
    if (!sn_gfield) begin
      sn_gfield   = 1'b1;
      sn_gz_count = '0;
      sn_gvalue   = '0;
      sn_phase    = SP_GZ;
      return;
    end
    if (v >= 5) v = v - 32'd5;
    if (v == 1) settle_type(vfts_pkg::FT_B);
    else if (v <= 4) settle_type(vfts_pkg::FT_P);
    else settle_type(vfts_pkg::FT_UNKNOWN);
  endfunction

  function automatic void golomb_bit(bit b);
    if (sn_phase == SP_GZ) begin
      if (!b) begin
        sn_gz_count = sn_gz_count + 6'd1;
        if (sn_gz_count > 31) settle_type(vfts_pkg::FT_UNKNOWN);
        return;
      end
      sn_gvalue = 32'd1;
      sn_phase  = SP_GI;
    end else begin
      sn_gvalue   = {sn_gvalue[30:0], b};
      sn_gz_count = sn_gz_count - 6'd1;
    end
    if (sn_gz_count == 0) golomb_field_done();
  endfunction

  function automatic void header_byte(logic [7:0] b);
    logic [4:0] nal;
    nal = b[4:0];
    if (model_mode == vfts_pkg::CODEC_H264) begin
      if (nal >= vfts_pkg::NAL_FIRST_SLICE && nal <= vfts_pkg::NAL_IDR_SLICE) begin
        if (nal == vfts_pkg::NAL_IDR_SLICE) begin
          settle_type(vfts_pkg::FT_I);
        end else if (b[6:5] != 2'd0) begin
          settle_type(vfts_pkg::FT_P);
        end else begin
          sn_phase    = SP_GZ;
          sn_gfield   = 1'b0;
          sn_gz_count = '0;
          sn_gvalue   = '0;
        end
      end else if (model_framing) begin
        sn_phase    = SP_SCAN;
        sn_zero_run = '0;
        void'(start_code_seen(b));
      end else begin
        settle_type(vfts_pkg::FT_UNKNOWN);
      end
      return;
    end
    if ((model_mode == vfts_pkg::CODEC_MPEG12 && b > vfts_pkg::MPEG12_LAST_PICTURE) ||
        (model_mode == vfts_pkg::CODEC_MPEG4 && b != vfts_pkg::MPEG4_VOP_CODE)) begin
      sn_phase    = SP_SCAN;
      sn_zero_run = '0;
      return;
    end
    sn_phase  = SP_TAIL;
    sn_offset = 3'd3;
  endfunction

  function automatic void picture_byte(logic [7:0] b);
    sn_offset = sn_offset + 3'd1;
    if (model_mode == vfts_pkg::CODEC_MPEG12) begin
      if (sn_offset == 5) begin
        if (b[5:3] <= 3) settle_type(vfts_pkg::frame_type_t'(b[4:3]));
        else settle_type(vfts_pkg::FT_UNKNOWN);
      end
    end else if (sn_offset == 4) begin
      case (b[7:6])
        2'd0: settle_type(vfts_pkg::FT_I);
        2'd1: settle_type(vfts_pkg::FT_P);
        2'd2: settle_type(vfts_pkg::FT_B);
        default: settle_type(vfts_pkg::FT_UNKNOWN);
      endcase
    end
  endfunction

  function automatic void sniff_byte(logic [7:0] b);
    if (sn_decided || model_mode == vfts_pkg::CODEC_NONE) return;
    case (sn_phase)
      SP_LEAD: begin
        if (model_mode == vfts_pkg::CODEC_H264 && model_framing) begin
          sn_phase    = SP_SCAN;
          sn_zero_run = '0;
          if (start_code_seen(b)) sn_phase = SP_HDR;
        end else if (sn_offset == ((model_mode == vfts_pkg::CODEC_H264) ? 3'd4 : 3'd3)) begin
          header_byte(b);
        end else begin
          sn_offset = sn_offset + 3'd1;
        end
      end
      SP_SCAN: if (start_code_seen(b)) sn_phase = SP_HDR;
      SP_HDR: header_byte(b);
      SP_TAIL: picture_byte(b);
      SP_GZ, SP_GI: begin
        for (int i = 7; i >= 0 && !sn_decided; i--) golomb_bit(b[i]);
      end
      default: settle_type(vfts_pkg::FT_UNKNOWN);
    endcase
  endfunction

  function automatic void apply_reg(logic [vfts_pkg::CFG_INDEX_W-1:0] idx,
                                    logic [vfts_pkg::CFG_DATA_W-1:0] val);
    if (idx == vfts_pkg::REG_CODEC_MODE) begin
      model_mode = val[1:0];
      clear_frame_state();
    end else if (idx == vfts_pkg::REG_FRAMING) begin
      model_framing = val[0];
      clear_frame_state();
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      model_mode    = vfts_pkg::CODEC_H264;
      model_framing = 1'b0;
      clear_frame_state();
    end else begin
      if (cfg_we) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        sniff_byte(stream_byte);
        bytes_seen++;
        if (last_byte) begin
          type_now  = sn_decided ? sn_type : vfts_pkg::FT_UNKNOWN;
          fixed_now = (fixed_types.size() > 0) ? fixed_types.pop_front() : NO_FIXED_TYPE;
          if (fixed_now != NO_FIXED_TYPE) type_now = vfts_pkg::frame_type_t'(fixed_now);
          expected_types.push_back(type_now);
          clear_frame_state();
        end
      end
      if (out_valid && out_ready) begin
        if (expected_types.size() == 0) begin
          $error("frame_type word with no frame pending: actual %0d", frame_type);
          fail_cnt++;
        end else begin
          type_now = expected_types.pop_front();
          if (frame_type !== type_now) begin
            $error("frame_type mismatch: expected %0d, actual %0d", type_now, frame_type);
            fail_cnt++;
          end
          frames_seen++;
          type_seen[type_now]++;
        end
      end
    end
  end

  function automatic logic [7:0] noisy_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'h01;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void put_noise(int n);
    repeat (n) frame_buf.push_back(noisy_byte());
  endfunction

  function automatic void put_start_code();
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h01);
  endfunction

  function automatic logic [7:0] non_slice_header();
    logic [2:0] top;
    logic [4:0] nal;
    top = 3'($urandom_range(0, 7));
    nal = 5'($urandom_range(0, 26));
    if (nal >= 1) nal = nal + 5'd5;
    return {top, nal};
  endfunction

  function automatic void put_ue(int unsigned v);
    logic [32:0] x;
    int n;
    x = {1'b0, v} + 33'd1;
    n = 0;
    while ((x >> n) != 0) n++;
    repeat (n - 1) slice_bits.push_back(1'b0);
    for (int i = n - 1; i >= 0; i--) slice_bits.push_back(x[i]);
  endfunction

  function automatic void put_long_zero_run();
    repeat ($urandom_range(28, 36)) slice_bits.push_back(1'b0);
    slice_bits.push_back(1'b1);
  endfunction

  function automatic void put_slice_payload();
    int r;
    logic [7:0] b;
    slice_bits.delete();
    if ($urandom_range(0, 19) == 0) put_long_zero_run();
    else if ($urandom_range(0, 3) == 0) put_ue($urandom_range(0, 5000));
    else put_ue($urandom_range(0, 10));
    r = $urandom_range(0, 19);
    if (r < 16) put_ue($urandom_range(0, 9));
    else if (r < 18) put_ue($urandom_range(10, 60));
    else put_long_zero_run();
    repeat ($urandom_range(0, 12)) slice_bits.push_back(1'($urandom_range(0, 1)));
    while (slice_bits.size() % 8 != 0) slice_bits.push_back(1'($urandom_range(0, 1)));
    for (int i = 0; i < slice_bits.size(); i += 8) begin
      for (int j = 0; j < 8; j++) b[7-j] = slice_bits[i+j];
      frame_buf.push_back(b);
    end
  endfunction

  function automatic void build_frame(logic [1:0] mode, logic framing);
    int n;
    logic [7:0] code;
    logic [4:0] nal;
    logic [1:0] nri;
    logic fbit;
    frame_buf.delete();
    if ($urandom_range(0, 15) == 0) begin
      put_noise($urandom_range(1, 12));
    end else begin
      case (mode)
        vfts_pkg::CODEC_H264: begin
          if (!framing) begin
            put_noise(4);
          end else begin
            if ($urandom_range(0, 1)) frame_buf.push_back(8'h00);
            put_start_code();
            repeat ($urandom_range(0, 2)) begin
              frame_buf.push_back(non_slice_header());
              put_noise($urandom_range(0, 4));
              if ($urandom_range(0, 1)) frame_buf.push_back(8'h00);
              put_start_code();
            end
          end
          n = $urandom_range(0, 9);
          nal = (n < 2) ? vfts_pkg::NAL_IDR_SLICE : 5'($urandom_range(1, 4));
          nri = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(1, 3)) : 2'd0;
          fbit = 1'($urandom_range(0, 1));
          if (n < 8) frame_buf.push_back({fbit, nri, nal});
          else frame_buf.push_back(non_slice_header());
          put_slice_payload();
        end
        vfts_pkg::CODEC_MPEG12: begin
          repeat ($urandom_range(0, 2)) begin
            put_start_code();
            frame_buf.push_back(8'($urandom_range(8'h81, 8'hFF)));
            put_noise($urandom_range(0, 3));
          end
          put_start_code();
          code = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 8'h80)) : 8'h00;
          frame_buf.push_back(code);
          put_noise($urandom_range(2, 4));
        end
        vfts_pkg::CODEC_MPEG4: begin
          repeat ($urandom_range(0, 2)) begin
            put_start_code();
            code = 8'($urandom_range(0, 255));
            if (code == vfts_pkg::MPEG4_VOP_CODE) code = 8'hB5;
            frame_buf.push_back(code);
            put_noise($urandom_range(0, 3));
          end
          put_start_code();
          frame_buf.push_back(vfts_pkg::MPEG4_VOP_CODE);
          put_noise($urandom_range(1, 3));
        end
        default: put_noise($urandom_range(1, 8));
      endcase
    end
    if ($urandom_range(0, 9) == 0 && frame_buf.size() > 1) begin
      n = $urandom_range(1, frame_buf.size() - 1);
      while (frame_buf.size() > n) void'(frame_buf.pop_back());
    end
  endfunction

  task automatic send_word(logic [7:0] b, logic last);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    stream_byte <= b;
    last_byte   <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Registers change only once the input is quiet and every frame result is out.
  task automatic write_reg(logic [vfts_pkg::CFG_INDEX_W-1:0] idx,
                           logic [vfts_pkg::CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (expected_types.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == vfts_pkg::REG_CODEC_MODE) cur_mode = val[1:0];
    else cur_framing = val[0];
  endtask

  task automatic set_config(logic [1:0] mode, logic framing);
    if (mode != cur_mode) write_reg(vfts_pkg::REG_CODEC_MODE, mode);
    if (framing != cur_framing) write_reg(vfts_pkg::REG_FRAMING, {1'b0, framing});
  endtask

  initial begin
    int stall;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    frame_row_t rows[$];
    int sent_bytes;
    int r;
    int waited;
    rows.push_back(frame_row_t'{vfts_pkg::CODEC_H264, 1'b0, 7, 96'h00000005_6588FF,
                                vfts_pkg::FT_I});
    rows.push_back(frame_row_t'{vfts_pkg::CODEC_H264, 1'b0, 6, 96'h00000005_419A,
                                vfts_pkg::FT_P});
    rows.push_back(frame_row_t'{vfts_pkg::CODEC_H264, 1'b0, 6, 96'hFFFFFFFF_01A0,
                                NO_FIXED_TYPE});
    rows.push_back(frame_row_t'{vfts_pkg::CODEC_H264, 1'b0, 6, 96'h00000005_019C,
                                NO_FIXED_TYPE});
    rows.push_back(frame_row_t'{vfts_pkg::CODEC_H264, 1'b0, 6, 96'h00000005_018B,
                                NO_FIXED_TYPE});
    rows.push_back(frame_row_t'{vfts_pkg::CODEC_H264, 1'b0, 6, 96'h00000005_01B0,
                                NO_FIXED_TYPE});
    rows.push_back(frame_row_t'{vfts_pkg::CODEC_H264, 1'b0, 6, 96'h00000005_6742,
                                vfts_pkg::FT_UNKNOWN});
    rows.push_back(frame_row_t'{vfts_pkg::CODEC_H264, 1'b0, 3, 96'h000000,
                                vfts_pkg::FT_UNKNOWN});
    rows.push_back(frame_row_t'{vfts_pkg::CODEC_H264, 1'b0, 10, 96'h00000005_01000000_0080,
                                vfts_pkg::FT_UNKNOWN});
    rows.push_back(frame_row_t'{vfts_pkg::CODEC_H264, 1'b0, 6, 96'h00000005_0100,
                                vfts_pkg::FT_UNKNOWN});
    rows.push_back(frame_row_t'{vfts_pkg::CODEC_H264, 1'b0, 1, 96'hFF,
                                vfts_pkg::FT_UNKNOWN});
    rows.push_back(frame_row_t'{vfts_pkg::CODEC_H264, 1'b1, 5, 96'h000001_6588,
                                vfts_pkg::FT_I});
    rows.push_back(frame_row_t'{vfts_pkg::CODEC_H264, 1'b1, 10, 96'h000001_6742_000001_419A,
                                NO_FIXED_TYPE});
    rows.push_back(frame_row_t'{vfts_pkg::CODEC_H264, 1'b1, 9, 96'h00000001_06_000001_25,
                                NO_FIXED_TYPE});
    rows.push_back(frame_row_t'{vfts_pkg::CODEC_H264, 1'b1, 8, 96'h000001_01_000003_80,
                                NO_FIXED_TYPE});
    rows.push_back(frame_row_t'{vfts_pkg::CODEC_MPEG12, 1'b1, 6, 96'h000001_00_0008,
                                vfts_pkg::FT_I});
    rows.push_back(frame_row_t'{vfts_pkg::CODEC_MPEG12, 1'b1, 12,
                                96'h000001_B3_1234_000001_00_3F10, NO_FIXED_TYPE});
    rows.push_back(frame_row_t'{vfts_pkg::CODEC_MPEG12, 1'b1, 6, 96'h000001_00_FFFF,
                                vfts_pkg::FT_UNKNOWN});
    rows.push_back(frame_row_t'{vfts_pkg::CODEC_MPEG12, 1'b1, 6, 96'h000001_80_0018,
                                NO_FIXED_TYPE});
    rows.push_back(frame_row_t'{vfts_pkg::CODEC_MPEG4, 1'b1, 5, 96'h000001_B6_40,
                                vfts_pkg::FT_P});
    rows.push_back(frame_row_t'{vfts_pkg::CODEC_MPEG4, 1'b1, 5, 96'h000001_B6_C0,
                                vfts_pkg::FT_UNKNOWN});
    rows.push_back(frame_row_t'{vfts_pkg::CODEC_MPEG4, 1'b1, 9, 96'h000001_20_000001_B6_80,
                                NO_FIXED_TYPE});
    rows.push_back(frame_row_t'{vfts_pkg::CODEC_MPEG4, 1'b1, 4, 96'h000001_B6,
                                vfts_pkg::FT_UNKNOWN});
    rows.push_back(frame_row_t'{vfts_pkg::CODEC_NONE, 1'b1, 6, 96'h000001_00_0008,
                                vfts_pkg::FT_UNKNOWN});

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    write_reg(vfts_pkg::REG_CODEC_MODE, vfts_pkg::CODEC_H264);
    write_reg(vfts_pkg::REG_FRAMING, 2'd0);

    sent_bytes = 0;
    foreach (rows[k]) begin
      set_config(rows[k].mode, rows[k].framing);
      fixed_types.push_back(rows[k].fixed_type);
      for (int i = 0; i < rows[k].len; i++)
        send_word(rows[k].data[(rows[k].len-1-i)*8 +: 8], i == rows[k].len - 1);
      sent_bytes += rows[k].len;
    end

    while (sent_bytes < ITEM_TARGET) begin
      r = $urandom_range(0, 10);
      if (r <= 3) write_reg(vfts_pkg::REG_CODEC_MODE, vfts_pkg::CODEC_H264);
      else if (r <= 6) write_reg(vfts_pkg::REG_CODEC_MODE, vfts_pkg::CODEC_MPEG12);
      else if (r <= 9) write_reg(vfts_pkg::REG_CODEC_MODE, vfts_pkg::CODEC_MPEG4);
      else write_reg(vfts_pkg::REG_CODEC_MODE, vfts_pkg::CODEC_NONE);
      write_reg(vfts_pkg::REG_FRAMING, 2'($urandom_range(0, 1)));
      phases++;
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(5, 25)) begin
        if (sent_bytes < ITEM_TARGET) begin
          build_frame(cur_mode, cur_framing);
          fixed_types.push_back(NO_FIXED_TYPE);
          foreach (frame_buf[i]) send_word(frame_buf[i], i == frame_buf.size() - 1);
          sent_bytes += frame_buf.size();
        end
      end
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    waited = 0;
    while (expected_types.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (expected_types.size() != 0) begin
      $error("%0d frame_type words never arrived", expected_types.size());
      fail_cnt++;
    end

    $display("Run covered %0d bytes in %0d frames over %0d random register settings.",
             bytes_seen, frames_seen, phases);
    $display("Frame types checked: %0d unknown, %0d I, %0d P, %0d B.",
             type_seen[vfts_pkg::FT_UNKNOWN], type_seen[vfts_pkg::FT_I],
             type_seen[vfts_pkg::FT_P], type_seen[vfts_pkg::FT_B]);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
